### rtl/core/itp_pkg.sv
// shared types, codes and character helpers of the infix to postfix converter
package itp_pkg;

    localparam int STACK_DEPTH = 32;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_MOD    = 8'h25;

    // stacked operator codes
    typedef enum logic [2:0] {
        OP_LP  = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_MOD = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CLS_OPND = 2'd0,
        CLS_LP   = 2'd1,
        CLS_RP   = 2'd2,
        CLS_OP   = 2'd3
    } t_cls;

    typedef enum logic [1:0] {
        SRC_CHAR = 2'd0,
        SRC_TOP  = 2'd1,
        SRC_ERR  = 2'd2
    } t_src;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_OVF  = 2'd1,
        ERR_UNM  = 2'd2
    } t_err;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic emit;
        t_src src;
        t_err err;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_cls cls;
        logic last;
        logic empty;
        logic full;
        logic top_lp;
        logic top_ge;
        logic emit_ok;
        logic fin_ok;
    } t_stat;

    // one result item
    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       run_last;
        logic       expr_end;
        t_err       err;
    } t_res;

    function automatic t_cls char_class(input logic [7:0] c);
        t_cls cls;
        case (c)
            CH_LPAREN: cls = CLS_LP;
            CH_RPAREN: cls = CLS_RP;
            CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD: cls = CLS_OP;
            default: cls = CLS_OPND;
        endcase
        return cls;
    endfunction

    function automatic t_op char_code(input logic [7:0] c);
        t_op op;
        case (c)
            CH_ADD:  op = OP_ADD;
            CH_SUB:  op = OP_SUB;
            CH_MUL:  op = OP_MUL;
            CH_DIV:  op = OP_DIV;
            CH_MOD:  op = OP_MOD;
            default: op = OP_LP;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] op_char(input t_op op);
        logic [7:0] c;
        case (op)
            OP_ADD:  c = CH_ADD;
            OP_SUB:  c = CH_SUB;
            OP_MUL:  c = CH_MUL;
            OP_DIV:  c = CH_DIV;
            OP_MOD:  c = CH_MOD;
            default: c = CH_LPAREN;
        endcase
        return c;
    endfunction

    // 1 for the tighter binding group
    function automatic logic op_prec(input t_op op);
        return op inside {OP_MUL, OP_DIV, OP_MOD};
    endfunction

endpackage

### rtl/core/itp_ctrl.sv
// sequencer of the infix to postfix converter
module itp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  itp_pkg::t_stat i_stat,
    output itp_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WORK  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state w_after;

    assign w_after = i_stat.last ? ST_FLUSH : ST_FIN;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WORK;
                end
            end
            ST_WORK: begin
                case (i_stat.cls)
                    itp_pkg::CLS_OPND: begin
                        if (i_stat.emit_ok) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = itp_pkg::SRC_CHAR;
                            n_state    = w_after;
                        end
                    end
                    itp_pkg::CLS_LP: begin
                        if (!i_stat.full) begin
                            o_cmd.push = 1'b1;
                            n_state    = w_after;
                        end else if (i_stat.emit_ok) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = itp_pkg::SRC_ERR;
                            o_cmd.err  = itp_pkg::ERR_OVF;
                            n_state    = w_after;
                        end
                    end
                    itp_pkg::CLS_RP: begin
                        if (i_stat.empty) begin
                            if (i_stat.emit_ok) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.src  = itp_pkg::SRC_ERR;
                                o_cmd.err  = itp_pkg::ERR_UNM;
                                n_state    = w_after;
                            end
                        end else if (i_stat.top_lp) begin
                            o_cmd.pop = 1'b1;
                            n_state   = w_after;
                        end else if (i_stat.emit_ok) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = itp_pkg::SRC_TOP;
                            o_cmd.pop  = 1'b1;
                        end
                    end
                    default: begin
                        if (!i_stat.empty && !i_stat.top_lp && i_stat.top_ge) begin
                            if (i_stat.emit_ok) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.src  = itp_pkg::SRC_TOP;
                                o_cmd.pop  = 1'b1;
                            end
                        end else if (!i_stat.full) begin
                            o_cmd.push = 1'b1;
                            n_state    = w_after;
                        end else if (i_stat.emit_ok) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = itp_pkg::SRC_ERR;
                            o_cmd.err  = itp_pkg::ERR_OVF;
                            n_state    = w_after;
                        end
                    end
                endcase
            end
            ST_FLUSH: begin
                if (i_stat.empty) begin
                    n_state = ST_FIN;
                end else if (i_stat.top_lp) begin
                    o_cmd.pop = 1'b1;
                end else if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = itp_pkg::SRC_TOP;
                    o_cmd.pop  = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_stat.fin_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/itp_dp.sv
// operator stack, held result and output register of the converter
module itp_dp #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    input  itp_pkg::t_cmd  i_cmd,
    output itp_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output itp_pkg::t_res  o_out,
    input  logic           i_out_ready
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [2:0]    r_mem [STACK_DEPTH];
    logic [2:0]    r_rd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    r_char;
    logic          r_last;
    itp_pkg::t_res r_hold;
    logic          r_hold_v;
    itp_pkg::t_res r_out;
    logic          r_out_v;
    itp_pkg::t_res n_out;
    itp_pkg::t_res w_new;
    logic          w_out_load;
    logic          w_out_free;
    logic          w_full;
    logic          w_push;
    itp_pkg::t_op  w_code;
    itp_pkg::t_op  w_top;

    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_push     = i_cmd.push && !w_full;
    assign w_code     = itp_pkg::char_code(r_char);
    assign w_top      = itp_pkg::t_op'(r_rd);
    assign w_out_free = !r_out_v || i_out_ready;

    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // top of stack tracks the next count
    assign w_rd_addr = AW'(n_count - 1'b1);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_count[AW-1:0]] <= w_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_rd <= w_code;
        end else begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        w_new          = '0;
        w_new.err      = itp_pkg::ERR_NONE;
        case (i_cmd.src)
            itp_pkg::SRC_CHAR: begin
                w_new.ch  = r_char;
                w_new.has = 1'b1;
            end
            itp_pkg::SRC_TOP: begin
                w_new.ch  = itp_pkg::op_char(w_top);
                w_new.has = 1'b1;
            end
            default: begin
                w_new.err = i_cmd.err;
            end
        endcase
    end

    always_comb begin
        w_out_load     = 1'b0;
        n_out          = r_hold;
        n_out.run_last = 1'b0;
        n_out.expr_end = 1'b0;
        if (i_cmd.emit && r_hold_v) begin
            w_out_load = 1'b1;
        end
        if (i_cmd.finish) begin
            if (r_hold_v) begin
                w_out_load     = 1'b1;
                n_out.run_last = 1'b1;
                n_out.expr_end = r_last;
            end else if (r_last) begin
                // bare end marker
                w_out_load     = 1'b1;
                n_out          = '0;
                n_out.err      = itp_pkg::ERR_NONE;
                n_out.run_last = 1'b1;
                n_out.expr_end = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char;
            r_last <= i_last;
        end
        if (i_cmd.emit) begin
            r_hold <= w_new;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_stat.cls     = itp_pkg::char_class(r_char);
        o_stat.last    = r_last;
        o_stat.empty   = (r_count == '0);
        o_stat.full    = w_full;
        o_stat.top_lp  = (w_top == itp_pkg::OP_LP);
        o_stat.top_ge  = itp_pkg::op_prec(w_top) >= itp_pkg::op_prec(w_code);
        o_stat.emit_ok = !r_hold_v || w_out_free;
        o_stat.fin_ok  = w_out_free || (!r_hold_v && !r_last);
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

### rtl/core/infix_to_postfix_converter.sv
// top level of the infix to postfix converter
//
// usage:
//   slave channel takes one expression character per item, tlast set on the
//   final character of an expression; master channel gives the postfix
//   characters, end markers and error markers, one result per item
// sequence:
//   a character is taken in the idle state, handled in the work state and
//   closed out in the finish state; every operator popped off the stack
//   adds a work step (one stack read port, one pop per cycle unless a
//   result has to wait for the output), and at expression end a flush
//   state pops every stacked entry before the close-out
//   results: an operand result reaches the output register at close-out; a result
//   waits in the holding register until the next one or close-out, so pushes,
//   dropped '(' and the flush cycles put the first result of an item later
// reset: synchronous, active low; empties the stack and drops any pending result
// stall:
//   while the output register is full and not taken, the sequencer waits
//   before any result that has to push a held one on; a finished result
//   can sit in the output register while the next character is already accepted
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // slave side
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_char
    input  logic       i_s_axis_tlast,   // expr_last
    // master side
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic [3:0] o_m_axis_tuser,   // [0] has_char, [1] expr_end, [3:2] error_code
    output logic       o_m_axis_tlast    // run_last
);

    itp_pkg::t_cmd w_cmd;
    itp_pkg::t_stat w_stat;
    itp_pkg::t_res w_out;

    // sequencer: decides push, pop and emit each cycle
    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // stack memory, result holding and output registers
    itp_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (w_out),
        .i_out_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = w_out.ch;
    assign o_m_axis_tuser = {w_out.err, w_out.expr_end, w_out.has};
    assign o_m_axis_tlast = w_out.run_last;

    // one character at a time: ready drops right after an accept
    a_one_at_a_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // the end of an expression is always the end of a run
    a_end_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("expression end without run end");

    // a character result never carries an error
    a_char_no_err : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tuser[3:2] == itp_pkg::ERR_NONE))
        else $error("character result with error code");

endmodule

### verif/postfix_checker.sv
// postfix result predictor and comparator for the infix to postfix converter
`timescale 1ns / 100ps

module postfix_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_char
    input  logic       i_s_axis_tlast,   // expr_last
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [7:0] out_char
    input  logic [3:0] i_m_axis_tuser,   // [0] has_char, [1] expr_end, [3:2] error_code
    input  logic       i_m_axis_tlast,   // run_last
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results,
    output int         o_exprs,
    output int         o_ovf_markers,
    output int         o_unm_markers
);

    itp_pkg::t_op  op_held [itp_pkg::STACK_DEPTH];
    int            op_depth;
    itp_pkg::t_res postfix_q [$];
    itp_pkg::t_res step_res;
    int            step_count;

    function automatic logic binds_tight(input itp_pkg::t_op op);
        return (op == itp_pkg::OP_MUL) || (op == itp_pkg::OP_DIV) || (op == itp_pkg::OP_MOD);
    endfunction

    function automatic logic [7:0] stacked_char(input itp_pkg::t_op op);
        case (op)
            itp_pkg::OP_ADD: return itp_pkg::CH_ADD;
            itp_pkg::OP_SUB: return itp_pkg::CH_SUB;
            itp_pkg::OP_MUL: return itp_pkg::CH_MUL;
            itp_pkg::OP_DIV: return itp_pkg::CH_DIV;
            itp_pkg::OP_MOD: return itp_pkg::CH_MOD;
            default:         return itp_pkg::CH_LPAREN;
        endcase
    endfunction

    // the newest result of a step is held back so its flags can still be set
    task automatic add_result(input logic [7:0] ch, input logic has, input itp_pkg::t_err err);
        if (step_count > 0)
            postfix_q.push_back(step_res);
        step_res.ch       = ch;
        step_res.has      = has;
        step_res.run_last = 1'b0;
        step_res.expr_end = 1'b0;
        step_res.err      = err;
        step_count++;
    endtask

    task automatic push_op(input itp_pkg::t_op op);
        if (op_depth >= itp_pkg::STACK_DEPTH) begin
            add_result(8'h00, 1'b0, itp_pkg::ERR_OVF);
        end else begin
            op_held[op_depth] = op;
            op_depth++;
        end
    endtask

    task automatic place_operator(input itp_pkg::t_op op);
        while (op_depth > 0 && op_held[op_depth-1] != itp_pkg::OP_LP &&
               binds_tight(op_held[op_depth-1]) >= binds_tight(op)) begin
            op_depth--;
            add_result(stacked_char(op_held[op_depth]), 1'b1, itp_pkg::ERR_NONE);
        end
        push_op(op);
    endtask

    task automatic shunt_char(input logic [7:0] ch, input logic last);
        itp_pkg::t_op top;
        logic         matched;
        step_count = 0;
        matched    = 1'b0;
        case (ch)
            itp_pkg::CH_RPAREN: begin
                while (op_depth > 0 && !matched) begin
                    top = op_held[op_depth-1];
                    op_depth--;
                    if (top == itp_pkg::OP_LP)
                        matched = 1'b1;
                    else
                        add_result(stacked_char(top), 1'b1, itp_pkg::ERR_NONE);
                end
                if (!matched)
                    add_result(8'h00, 1'b0, itp_pkg::ERR_UNM);
            end
            itp_pkg::CH_LPAREN: push_op(itp_pkg::OP_LP);
            itp_pkg::CH_ADD:    place_operator(itp_pkg::OP_ADD);
            itp_pkg::CH_SUB:    place_operator(itp_pkg::OP_SUB);
            itp_pkg::CH_MUL:    place_operator(itp_pkg::OP_MUL);
            itp_pkg::CH_DIV:    place_operator(itp_pkg::OP_DIV);
            itp_pkg::CH_MOD:    place_operator(itp_pkg::OP_MOD);
            default:            add_result(ch, 1'b1, itp_pkg::ERR_NONE);
        endcase
        if (last) begin
            // flush, open parens vanish silently
            while (op_depth > 0) begin
                op_depth--;
                if (op_held[op_depth] != itp_pkg::OP_LP)
                    add_result(stacked_char(op_held[op_depth]), 1'b1, itp_pkg::ERR_NONE);
            end
            if (step_count == 0)
                add_result(8'h00, 1'b0, itp_pkg::ERR_NONE);
            step_res.expr_end = 1'b1;
        end
        if (step_count > 0) begin
            step_res.run_last = 1'b1;
            postfix_q.push_back(step_res);
        end
    endtask

    task automatic check_result();
        itp_pkg::t_res got;
        itp_pkg::t_res want;
        got.ch       = i_m_axis_tdata;
        got.has      = i_m_axis_tuser[0];
        got.run_last = i_m_axis_tlast;
        got.expr_end = i_m_axis_tuser[1];
        got.err      = itp_pkg::t_err'(i_m_axis_tuser[3:2]);
        o_results++;
        if (postfix_q.size() == 0) begin
            $display("%0t: unexpected item ch=%h has=%b run_last=%b expr_end=%b err=%0d",
                     $time, got.ch, got.has, got.run_last, got.expr_end, got.err);
            o_fail_count++;
        end else begin
            want = postfix_q.pop_front();
            if (got.ch !== want.ch || got.has !== want.has || got.run_last !== want.run_last ||
                got.expr_end !== want.expr_end || got.err !== want.err) begin
                $display("%0t: expected ch=%h has=%b run_last=%b expr_end=%b err=%0d",
                         $time, want.ch, want.has, want.run_last, want.expr_end, want.err);
                $display("%0t:   actual ch=%h has=%b run_last=%b expr_end=%b err=%0d",
                         $time, got.ch, got.has, got.run_last, got.expr_end, got.err);
                o_fail_count++;
            end
            if (want.expr_end)
                o_exprs++;
            if (want.err == itp_pkg::ERR_OVF)
                o_ovf_markers++;
            if (want.err == itp_pkg::ERR_UNM)
                o_unm_markers++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_depth      = 0;
            postfix_q.delete();
            o_fail_count  = 0;
            o_results     = 0;
            o_exprs       = 0;
            o_ovf_markers = 0;
            o_unm_markers = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                shunt_char(i_s_axis_tdata, i_s_axis_tlast);
            if (i_m_axis_tvalid && i_m_axis_tready)
                check_result();
        end
        o_pending <= postfix_q.size();
    end

endmodule

### verif/tb.sv
// testbench top for the infix to postfix converter: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] in_char
    logic       s_axis_tlast;    // expr_last
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_char
    logic [3:0] m_axis_tuser;    // [0] has_char, [1] expr_end, [3:2] error_code
    logic       m_axis_tlast;    // run_last

    int fail_count;
    int pending;
    int result_count;
    int expr_count;
    int ovf_count;
    int unm_count;

    // flow control knobs of the sender and the receiver
    int   items_sent  = 0;
    int   hold_cycles = 0;
    logic tx_burst    = 1'b0;
    logic rx_burst    = 1'b0;

    // characters of the expression being built, with their end flags
    logic [7:0] char_buf [$];
    logic       last_buf [$];

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    infix_to_postfix_converter u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    postfix_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (result_count),
        .o_exprs         (expr_count),
        .o_ovf_markers   (ovf_count),
        .o_unm_markers   (unm_count)
    );

    // operators and parens, everything else is an operand
    function automatic logic is_syntax_char(input logic [7:0] c);
        case (c)
            itp_pkg::CH_LPAREN, itp_pkg::CH_RPAREN, itp_pkg::CH_ADD, itp_pkg::CH_SUB,
            itp_pkg::CH_MUL, itp_pkg::CH_DIV, itp_pkg::CH_MOD: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // half letters, half any non-syntax byte so every data bit toggles
    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(0, 1)) begin
            c = 8'h61 + 8'($urandom_range(0, 25));
        end else begin
            c = 8'($urandom_range(0, 255));
            while (is_syntax_char(c))
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 4))
            0:       return itp_pkg::CH_ADD;
            1:       return itp_pkg::CH_SUB;
            2:       return itp_pkg::CH_MUL;
            3:       return itp_pkg::CH_DIV;
            default: return itp_pkg::CH_MOD;
        endcase
    endfunction

    task automatic queue_item(input logic [7:0] c, input logic last);
        char_buf.push_back(c);
        last_buf.push_back(last);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_item(s[i], i == s.len() - 1);
    endtask

    // operands and operators alternate, parens nest up to six deep
    task automatic build_wellformed();
        int terms;
        int open;
        terms = $urandom_range(1, 7);
        open  = 0;
        for (int i = 0; i < terms; i++) begin
            while (open < 6 && $urandom_range(0, 3) == 0) begin
                queue_item(itp_pkg::CH_LPAREN, 1'b0);
                open++;
            end
            queue_item(pick_operand(), 1'b0);
            while (open > 0 && $urandom_range(0, 2) == 0) begin
                queue_item(itp_pkg::CH_RPAREN, 1'b0);
                open--;
            end
            if (i < terms - 1)
                queue_item(pick_operator(), 1'b0);
        end
        // now and then leave a paren open for the flush to drop
        while (open > 0 && $urandom_range(0, 4) != 0) begin
            queue_item(itp_pkg::CH_RPAREN, 1'b0);
            open--;
        end
    endtask

    // junk order, stray close parens and early expression ends
    task automatic build_noise();
        logic [7:0] c;
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0:       c = 8'($urandom_range(0, 255));
                1:       c = pick_operator();
                2:       c = itp_pkg::CH_LPAREN;
                default: c = itp_pkg::CH_RPAREN;
            endcase
            queue_item(c, $urandom_range(0, 4) == 0);
        end
    endtask

    // nesting deep enough to hit the stack limit most of the time
    task automatic build_deep();
        logic [7:0] c;
        logic prev_lp;
        int n;
        n = $urandom_range(34, 40);
        prev_lp = 1'b0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                c = pick_operand();
            else if (!prev_lp || $urandom_range(0, 1))
                c = itp_pkg::CH_LPAREN;
            else
                c = pick_operator();
            prev_lp = (c == itp_pkg::CH_LPAREN);
            queue_item(c, 1'b0);
        end
        for (int i = $urandom_range(0, 3); i > 0; i--)
            queue_item(itp_pkg::CH_RPAREN, 1'b0);
    endtask

    // one item per handshake, with a random gap unless bursting
    task automatic send_item(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // the final buffered character always closes the expression
    task automatic send_queued();
        logic [7:0] c;
        logic last;
        while (char_buf.size() > 0) begin
            c    = char_buf.pop_front();
            last = last_buf.pop_front();
            send_item(c, last || char_buf.size() == 0);
        end
    endtask

    // stop offering until every predicted result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls per item, bursts, and one long hold on request
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 6);
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // main stimulus
    initial begin
        int goal;
        int kind;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        rst_n         <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, every operator, precedence, parens,
        // unmatched close, lone open paren and lone operator at expression end
        queue_item(8'h00, 1'b1);
        queue_text("a+b*c");
        queue_text("(a-b)/c%#");
        queue_item(itp_pkg::CH_RPAREN, 1'b1);
        queue_item(itp_pkg::CH_LPAREN, 1'b1);
        queue_item(itp_pkg::CH_ADD, 1'b1);
        queue_item(8'hFF, 1'b1);
        send_queued();
        wait_drained();

        // back pressure: output held for a long stretch while the sender
        // keeps offering alternating operand and operator items, so the input has to stall
        hold_cycles = 200;
        tx_burst    = 1'b1;
        for (int k = 0; k < 24; k++)
            queue_item(k[0] ? pick_operator() : pick_operand(), 1'b0);
        send_queued();
        tx_burst = 1'b0;
        wait_drained();

        // guaranteed overflow: 36 pushes against a 32 entry stack, then a full flush
        for (int k = 0; k < 36; k++)
            queue_item(k[0] ? pick_operator() : itp_pkg::CH_LPAREN, 1'b0);
        send_queued();
        wait_drained();

        // random expressions, mostly well formed
        goal = items_sent + 170;
        while (items_sent < goal) begin
            if ($urandom_range(0, 4) == 0)
                tx_burst = ~tx_burst;
            if ($urandom_range(0, 4) == 0)
                rx_burst = ~rx_burst;
            kind = $urandom_range(0, 19);
            if (kind < 14)
                build_wellformed();
            else if (kind < 18)
                build_noise();
            else
                build_deep();
            send_queued();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        // drain, then give a deep flush time to show any stray result
        wait_drained();
        repeat (64) @(posedge clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);

        $display("covered %0d characters over %0d expressions, %0d postfix items checked",
                 items_sent, expr_count, result_count);
        $display("stack overflow markers %0d, unmatched close paren markers %0d",
                 ovf_count, unm_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS infix_to_postfix_converter");
        else
            $display("FAIL infix_to_postfix_converter");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("FAIL infix_to_postfix_converter");
        $finish;
    end

endmodule
